>>> hw/rtl/assert_macros.svh
// Assertion helpers for the motor drive controller.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define MDC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MDC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MDC_ASSERT_IMP(lbl, ante, cons, msg)
`define MDC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Types, constants and the microprogram of the motor drive controller.
// ----------------------------------------------------------------------------
package mdc_pkg;

	localparam int DUTY_MAX_DEF    = 800;
	localparam int SERVO_RANGE_DEF = 2500;

	localparam int GAIN_W  = 16;
	localparam int SPEED_W = 8;
	localparam int SERVO_W = 12;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int MUL_IN_W = 21;
	localparam int MUL_W   = 2 * MUL_IN_W;
	localparam int PC_W    = 4;
	localparam int PROG_LEN = 15;

	// ceil(2^26 / 127): exact quotient for dividends below 2^19
	localparam logic [19:0] SERVO_RECIP = 20'd528417;
	localparam int SERVO_SHIFT = 26;

	localparam logic signed [GAIN_W-1:0]  P_GAIN_RST      = 16'sd256;
	localparam logic signed [GAIN_W-1:0]  I_GAIN_RST      = 16'sd0;
	localparam logic signed [GAIN_W-1:0]  D_GAIN_RST      = 16'sd0;
	localparam logic signed [GAIN_W-1:0]  INTEG_UPPER_RST = 16'sd1000;
	localparam logic signed [GAIN_W-1:0]  INTEG_LOWER_RST = -16'sd1000;
	localparam logic [SERVO_W-1:0]        SERVO_LOW_RST   = 12'd100;
	localparam logic [SERVO_W-1:0]        SERVO_HIGH_RST  = 12'd200;
	localparam logic [SPEED_W-1:0]        MAX_SPEED_RST   = 8'd5;

	// direction line levels: bit0 forward, bit1 reverse, bit2 hard brake
	localparam logic [2:0] PINS_OFF   = 3'b000;
	localparam logic [2:0] PINS_FWD   = 3'b001;
	localparam logic [2:0] PINS_REV   = 3'b010;
	localparam logic [2:0] PINS_BRAKE = 3'b100;

	localparam logic [SPEED_W-1:0] REVERSE_THRESH = 8'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_P_GAIN,
		CFG_I_GAIN,
		CFG_D_GAIN,
		CFG_INTEG_UPPER,
		CFG_INTEG_LOWER,
		CFG_SERVO_LOW,
		CFG_SERVO_HIGH,
		CFG_MAX_SPEED
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_SPD_FWD,
		MUL_SPD_REV,
		MUL_SERVO_A,
		MUL_SERVO_B,
		MUL_P_ERR,
		MUL_I_INT,
		MUL_D_DM
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [3:0] {
		DST_NONE,
		DST_CLEAR,
		DST_TGT_FWD,
		DST_TGT_REV,
		DST_DIR,
		DST_STOP,
		DST_SERVO,
		DST_ERR,
		DST_DUTY
	} dest_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_TICK,
		JMP_STOP,
		JMP_ALWAYS
	} jmp_t;

	typedef struct packed {
		mul_sel_t         mul;
		acc_op_t          acc;
		dest_t            dst;
		jmp_t             jmp;
		logic [PC_W-1:0]  target;
		logic             fin;
	} ucw_t;

	localparam logic [PC_W-1:0] PC_DISPATCH = 4'd0;
	localparam logic [PC_W-1:0] PC_STOP     = 4'd5;
	localparam logic [PC_W-1:0] PC_SERVO    = 4'd6;
	localparam logic [PC_W-1:0] PC_TICK     = 4'd9;

	function automatic ucw_t uc(input mul_sel_t m, input acc_op_t a, input dest_t d,
			input jmp_t j, input logic [PC_W-1:0] t, input logic f);
		ucw_t w;
		w.mul    = m;
		w.acc    = a;
		w.dst    = d;
		w.jmp    = j;
		w.target = t;
		w.fin    = f;
		return w;
	endfunction

	// Microprogram. Commands run 0-4 (or 0,1,5 on stop) then 6-8; ticks run 0,9-14.
	function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
		ucw_t w;
		unique case (pc)
			4'd0:    w = uc(MUL_NONE,    ACC_HOLD, DST_CLEAR,   JMP_TICK,   PC_TICK,     1'b0);
			4'd1:    w = uc(MUL_SPD_FWD, ACC_HOLD, DST_NONE,    JMP_STOP,   PC_STOP,     1'b0);
			4'd2:    w = uc(MUL_SPD_REV, ACC_HOLD, DST_TGT_FWD, JMP_NONE,   PC_DISPATCH, 1'b0);
			4'd3:    w = uc(MUL_NONE,    ACC_HOLD, DST_TGT_REV, JMP_NONE,   PC_DISPATCH, 1'b0);
			4'd4:    w = uc(MUL_NONE,    ACC_HOLD, DST_DIR,     JMP_ALWAYS, PC_SERVO,    1'b0);
			4'd5:    w = uc(MUL_NONE,    ACC_HOLD, DST_STOP,    JMP_NONE,   PC_DISPATCH, 1'b0);
			4'd6:    w = uc(MUL_SERVO_A, ACC_HOLD, DST_NONE,    JMP_NONE,   PC_DISPATCH, 1'b0);
			4'd7:    w = uc(MUL_SERVO_B, ACC_HOLD, DST_NONE,    JMP_NONE,   PC_DISPATCH, 1'b0);
			4'd8:    w = uc(MUL_NONE,    ACC_HOLD, DST_SERVO,   JMP_NONE,   PC_DISPATCH, 1'b1);
			4'd9:    w = uc(MUL_NONE,    ACC_HOLD, DST_ERR,     JMP_NONE,   PC_DISPATCH, 1'b0);
			4'd10:   w = uc(MUL_P_ERR,   ACC_HOLD, DST_NONE,    JMP_NONE,   PC_DISPATCH, 1'b0);
			4'd11:   w = uc(MUL_I_INT,   ACC_LOAD, DST_NONE,    JMP_NONE,   PC_DISPATCH, 1'b0);
			4'd12:   w = uc(MUL_D_DM,    ACC_ADD,  DST_NONE,    JMP_NONE,   PC_DISPATCH, 1'b0);
			4'd13:   w = uc(MUL_NONE,    ACC_ADD,  DST_NONE,    JMP_NONE,   PC_DISPATCH, 1'b0);
			4'd14:   w = uc(MUL_NONE,    ACC_HOLD, DST_DUTY,    JMP_NONE,   PC_DISPATCH, 1'b1);
			default: w = uc(MUL_NONE,    ACC_HOLD, DST_NONE,    JMP_NONE,   PC_DISPATCH, 1'b1);
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/mdc_cmd_if.sv
// ----------------------------------------------------------------------------
// mdc_cmd_if
// Input channel: user commands and control ticks.
// ----------------------------------------------------------------------------
interface mdc_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  action;
	logic [mdc_pkg::SPEED_W-1:0]           fwd_cmd;
	logic [mdc_pkg::SPEED_W-1:0]           rev_cmd;
	logic signed [mdc_pkg::SPEED_W-1:0]    steer_cmd;
	logic                                  stop_cmd;
	logic [mdc_pkg::SPEED_W-1:0]           measured_speed;

	modport source (output valid, action, fwd_cmd, rev_cmd, steer_cmd, stop_cmd,
		measured_speed, input ready);
	modport sink (input valid, action, fwd_cmd, rev_cmd, steer_cmd, stop_cmd,
		measured_speed, output ready);
endinterface

>>> hw/rtl/mdc_res_if.sv
// ----------------------------------------------------------------------------
// mdc_res_if
// Result channel: motor duty, direction lines and servo duty.
// ----------------------------------------------------------------------------
interface mdc_res_if #(
	parameter int DUTY_W = 10
);
	logic                          valid;
	logic                          ready;
	logic [DUTY_W-1:0]             motor_duty;
	logic                          duty_written;
	logic                          fwd_pin;
	logic                          rev_pin;
	logic                          hard_brake;
	logic [mdc_pkg::SERVO_W-1:0]   servo_duty;
	logic                          servo_written;

	modport source (output valid, motor_duty, duty_written, fwd_pin, rev_pin, hard_brake,
		servo_duty, servo_written, input ready);
	modport sink (input valid, motor_duty, duty_written, fwd_pin, rev_pin, hard_brake,
		servo_duty, servo_written, output ready);
endinterface

>>> hw/rtl/motor_drive_pid_controller.sv
// ----------------------------------------------------------------------------
// motor_drive_pid_controller
// Direction, braking and steering control with a PID speed loop.
// ----------------------------------------------------------------------------
// Each transaction on cmd is a user command (action 0) or a control tick
// (action 1) and yields exactly one transaction on res. A command hard-brakes
// on stop_cmd, otherwise sets the speed targets to max_speed*x/255, brakes on a
// direction reversal or sets the direction lines, and soft-brakes when both
// requests are zero; every command also updates the servo duty from steer_cmd.
// A tick runs one PID step on measured_speed with a clamped integrator and the
// derivative taken on the measurement; the duty is clamped to 0..DUTY_MAX and
// driven only while the drive is active. The block works on one transaction at
// a time: a small microprogram steps a datapath built around one shared 21x21
// multiplier, one step per cycle unless the last step stalls. A finished result
// waits in the output register while the next transaction is taken; only the
// last program step stalls if that register is still full. Configuration
// writes go in through cfg_we/cfg_index/cfg_data and take effect at once;
// write them only while no transaction is in flight. There is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module motor_drive_pid_controller #(
	parameter int DUTY_MAX    = mdc_pkg::DUTY_MAX_DEF,
	parameter int SERVO_RANGE = mdc_pkg::SERVO_RANGE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	mdc_cmd_if.sink                           cmd,
	mdc_res_if.source                         res,
	input  logic                              cfg_we,
	input  logic [mdc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mdc_pkg::CFG_W-1:0]         cfg_data
);

	localparam int DUTY_W = $clog2(DUTY_MAX + 1);
	localparam int MUL_W  = mdc_pkg::MUL_W;
	localparam int MIN_W  = mdc_pkg::MUL_IN_W;
	localparam int PC_W   = mdc_pkg::PC_W;

	localparam logic signed [MUL_W-1:0] DUTY_MAX_L   = MUL_W'(DUTY_MAX);
	localparam logic [DUTY_W-1:0]       DUTY_MAX_D   = DUTY_W'(DUTY_MAX);
	localparam logic [12:0]             SERVO_RANGE_L = 13'(SERVO_RANGE);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [15:0] p_gain_q, i_gain_q, d_gain_q, integ_upper_q, integ_lower_q;
	logic [11:0]        servo_low_q, servo_high_q;
	logic [7:0]         max_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q      <= mdc_pkg::P_GAIN_RST;
			i_gain_q      <= mdc_pkg::I_GAIN_RST;
			d_gain_q      <= mdc_pkg::D_GAIN_RST;
			integ_upper_q <= mdc_pkg::INTEG_UPPER_RST;
			integ_lower_q <= mdc_pkg::INTEG_LOWER_RST;
			servo_low_q   <= mdc_pkg::SERVO_LOW_RST;
			servo_high_q  <= mdc_pkg::SERVO_HIGH_RST;
			max_speed_q   <= mdc_pkg::MAX_SPEED_RST;
		end else if (cfg_we) begin
			unique case (mdc_pkg::cfg_idx_t'(cfg_index))
				mdc_pkg::CFG_P_GAIN:      p_gain_q      <= cfg_data;
				mdc_pkg::CFG_I_GAIN:      i_gain_q      <= cfg_data;
				mdc_pkg::CFG_D_GAIN:      d_gain_q      <= cfg_data;
				mdc_pkg::CFG_INTEG_UPPER: integ_upper_q <= cfg_data;
				mdc_pkg::CFG_INTEG_LOWER: integ_lower_q <= cfg_data;
				mdc_pkg::CFG_SERVO_LOW:   servo_low_q   <= cfg_data[11:0];
				mdc_pkg::CFG_SERVO_HIGH:  servo_high_q  <= cfg_data[11:0];
				mdc_pkg::CFG_MAX_SPEED:   max_speed_q   <= cfg_data[7:0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	logic             busy_q;
	logic [PC_W-1:0]  pc_q;
	logic             out_valid_q;
	mdc_pkg::ucw_t    cw;
	logic             cmd_take;
	logic             res_take;
	logic             step_en;
	logic             jump;

	// Latched transaction
	logic             action_q;
	logic [7:0]       fwd_q, rev_q, meas_q;
	logic [7:0]       steer_q;
	logic             stop_q;

	assign cw        = mdc_pkg::ucode(pc_q);
	assign cmd.ready = !busy_q;
	assign cmd_take  = cmd.valid && !busy_q;
	assign res_take  = out_valid_q && res.ready;
	// hold the final step while the previous result still sits unaccepted
	assign step_en   = busy_q && !(cw.fin && out_valid_q && !res.ready);

	always_comb begin
		unique case (cw.jmp)
			mdc_pkg::JMP_NONE:   jump = 1'b0;
			mdc_pkg::JMP_TICK:   jump = action_q;
			mdc_pkg::JMP_STOP:   jump = stop_q;
			mdc_pkg::JMP_ALWAYS: jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= mdc_pkg::PC_DISPATCH;
		end else if (cmd_take) begin
			busy_q <= 1'b1;
			pc_q   <= mdc_pkg::PC_DISPATCH;
		end else if (step_en) begin
			if (cw.fin) begin
				busy_q <= 1'b0;
				pc_q   <= mdc_pkg::PC_DISPATCH;
			end else if (jump) begin
				pc_q   <= cw.target;
			end else begin
				pc_q   <= pc_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			action_q <= cmd.action;
			fwd_q    <= cmd.fwd_cmd;
			rev_q    <= cmd.rev_cmd;
			steer_q  <= cmd.steer_cmd;
			stop_q   <= cmd.stop_cmd;
			meas_q   <= cmd.measured_speed;
		end
	end

	// ------------------------------------------------------------------
	// Shared multiplier and accumulator
	// ------------------------------------------------------------------
	logic signed [MIN_W-1:0] mul_a, mul_b;
	logic signed [MUL_W-1:0] prod_q, acc_q;
	logic signed [9:0]       err_q, dm_q;
	logic signed [15:0]      integ_q;
	logic [7:0]              steer_off;
	logic [11:0]             servo_span;

	// -128 saturates to full left, so it maps like -127
	assign steer_off  = (steer_q == 8'h80) ? 8'd0 : (steer_q + 8'd127);
	assign servo_span = (servo_high_q > servo_low_q) ? (servo_high_q - servo_low_q) : 12'd0;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cw.mul)
			mdc_pkg::MUL_NONE: begin
				mul_a = '0;
				mul_b = '0;
			end
			mdc_pkg::MUL_SPD_FWD: begin
				mul_a = {13'd0, max_speed_q};
				mul_b = {13'd0, fwd_q};
			end
			mdc_pkg::MUL_SPD_REV: begin
				mul_a = {13'd0, max_speed_q};
				mul_b = {13'd0, rev_q};
			end
			mdc_pkg::MUL_SERVO_A: begin
				mul_a = {13'd0, steer_off};
				mul_b = {9'd0, servo_span};
			end
			mdc_pkg::MUL_SERVO_B: begin
				// halve the span product, then divide by 127 through the reciprocal
				mul_a = {1'b0, prod_q[20:1]};
				mul_b = {1'b0, mdc_pkg::SERVO_RECIP};
			end
			mdc_pkg::MUL_P_ERR: begin
				mul_a = {{5{p_gain_q[15]}}, p_gain_q};
				mul_b = {{11{err_q[9]}}, err_q};
			end
			mdc_pkg::MUL_I_INT: begin
				mul_a = {{5{i_gain_q[15]}}, i_gain_q};
				mul_b = {{5{integ_q[15]}}, integ_q};
			end
			mdc_pkg::MUL_D_DM: begin
				mul_a = {{5{d_gain_q[15]}}, d_gain_q};
				mul_b = {{11{dm_q[9]}}, dm_q};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (step_en && (cw.mul != mdc_pkg::MUL_NONE)) begin
			prod_q <= mul_a * mul_b;
		end
		if (step_en) begin
			unique case (cw.acc)
				mdc_pkg::ACC_HOLD: acc_q <= acc_q;
				mdc_pkg::ACC_LOAD: acc_q <= prod_q;
				mdc_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
				default:           acc_q <= acc_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Destination logic and controller state
	// ------------------------------------------------------------------
	logic        dir_fwd_q, active_q;
	logic [7:0]  tgt_fwd_q, tgt_rev_q, last_meas_q;
	logic [2:0]  pins_q;

	logic        dir_fwd_d, active_d;
	logic [7:0]  tgt_fwd_d, tgt_rev_d, last_meas_d;
	logic [2:0]  pins_d;
	logic signed [15:0] integ_d;
	logic signed [9:0]  err_d, dm_d;

	// per-transaction result, built up over the program
	logic [DUTY_W-1:0] wduty_q, wduty_d;
	logic              wdwr_q, wdwr_d;
	logic [11:0]       wservo_q, wservo_d;
	logic              wswr_q, wswr_d;

	logic [16:0]       div255_sum;
	logic [7:0]        tgt_sel;
	logic signed [17:0] integ_sum;
	logic signed [MUL_W-1:0] duty_shift;
	logic [12:0]       servo_sum;

	// floor(x/255) = (x + (x >> 8) + 1) >> 8 for x up to 65534
	assign div255_sum = {1'b0, prod_q[15:0]} + {9'd0, prod_q[15:8]} + 17'd1;
	assign tgt_sel    = dir_fwd_q ? tgt_fwd_q : tgt_rev_q;
	assign err_d      = $signed({2'b00, tgt_sel}) - $signed({2'b00, meas_q});
	assign dm_d       = $signed({2'b00, last_meas_q}) - $signed({2'b00, meas_q});
	assign integ_sum  = {{2{integ_q[15]}}, integ_q} + {{8{err_d[9]}}, err_d};
	assign duty_shift = acc_q >>> 8;
	assign servo_sum  = {1'b0, servo_low_q}
		+ {1'b0, prod_q[mdc_pkg::SERVO_SHIFT+11:mdc_pkg::SERVO_SHIFT]};

	always_comb begin
		dir_fwd_d   = dir_fwd_q;
		active_d    = active_q;
		tgt_fwd_d   = tgt_fwd_q;
		tgt_rev_d   = tgt_rev_q;
		last_meas_d = last_meas_q;
		pins_d      = pins_q;
		integ_d     = integ_q;
		wduty_d     = wduty_q;
		wdwr_d      = wdwr_q;
		wservo_d    = wservo_q;
		wswr_d      = wswr_q;
		unique case (cw.dst)
			mdc_pkg::DST_NONE: begin
				wdwr_d = wdwr_q;
			end
			mdc_pkg::DST_CLEAR: begin
				wduty_d  = '0;
				wdwr_d   = 1'b0;
				wservo_d = '0;
				wswr_d   = 1'b0;
			end
			mdc_pkg::DST_TGT_FWD: begin
				tgt_fwd_d = div255_sum[15:8];
			end
			mdc_pkg::DST_TGT_REV: begin
				tgt_rev_d = div255_sum[15:8];
			end
			mdc_pkg::DST_DIR: begin
				if (((fwd_q > mdc_pkg::REVERSE_THRESH) && !dir_fwd_q)
						|| ((rev_q > mdc_pkg::REVERSE_THRESH) && dir_fwd_q)) begin
					active_d = 1'b0;
					pins_d   = mdc_pkg::PINS_BRAKE;
					wduty_d  = '0;
					wdwr_d   = 1'b1;
				end else if (fwd_q != 8'd0) begin
					pins_d    = mdc_pkg::PINS_FWD;
					dir_fwd_d = 1'b1;
					active_d  = 1'b1;
				end else begin
					pins_d    = mdc_pkg::PINS_REV;
					dir_fwd_d = 1'b0;
					active_d  = 1'b1;
				end
				// both requests zero: coast with all lines low
				if ((fwd_q == 8'd0) && (rev_q == 8'd0)) begin
					active_d = 1'b0;
					pins_d   = mdc_pkg::PINS_OFF;
					wduty_d  = '0;
					wdwr_d   = 1'b1;
				end
			end
			mdc_pkg::DST_STOP: begin
				active_d = 1'b0;
				pins_d   = mdc_pkg::PINS_BRAKE;
				wduty_d  = '0;
				wdwr_d   = 1'b1;
			end
			mdc_pkg::DST_SERVO: begin
				wservo_d = (servo_sum > SERVO_RANGE_L) ? SERVO_RANGE_L[11:0] : servo_sum[11:0];
				wswr_d   = 1'b1;
			end
			mdc_pkg::DST_ERR: begin
				// upper clamp wins when the limits are inverted
				if (integ_sum > $signed({{2{integ_upper_q[15]}}, integ_upper_q})) begin
					integ_d = integ_upper_q;
				end else if (integ_sum < $signed({{2{integ_lower_q[15]}}, integ_lower_q})) begin
					integ_d = integ_lower_q;
				end else begin
					integ_d = integ_sum[15:0];
				end
				last_meas_d = meas_q;
			end
			mdc_pkg::DST_DUTY: begin
				if (!active_q || (acc_q <= 0)) begin
					wduty_d = '0;
				end else if (duty_shift > DUTY_MAX_L) begin
					wduty_d = DUTY_MAX_D;
				end else begin
					wduty_d = duty_shift[DUTY_W-1:0];
				end
				wdwr_d = active_q;
			end
			default: begin
				wdwr_d = wdwr_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_fwd_q   <= 1'b1;
			active_q    <= 1'b0;
			tgt_fwd_q   <= '0;
			tgt_rev_q   <= '0;
			last_meas_q <= '0;
			pins_q      <= mdc_pkg::PINS_OFF;
			integ_q     <= '0;
		end else if (step_en) begin
			dir_fwd_q   <= dir_fwd_d;
			active_q    <= active_d;
			tgt_fwd_q   <= tgt_fwd_d;
			tgt_rev_q   <= tgt_rev_d;
			last_meas_q <= last_meas_d;
			pins_q      <= pins_d;
			integ_q     <= integ_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			wduty_q  <= wduty_d;
			wdwr_q   <= wdwr_d;
			wservo_q <= wservo_d;
			wswr_q   <= wswr_d;
			if (cw.dst == mdc_pkg::DST_ERR) begin
				err_q <= err_d;
				dm_q  <= dm_d;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register: load on the final step, drop once taken
	// ------------------------------------------------------------------
	logic [DUTY_W-1:0] rduty_q;
	logic              rdwr_q;
	logic [2:0]        rpins_q;
	logic [11:0]       rservo_q;
	logic              rswr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && cw.fin) begin
			out_valid_q <= 1'b1;
		end else if (res_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && cw.fin) begin
			rduty_q  <= wduty_d;
			rdwr_q   <= wdwr_d;
			rpins_q  <= pins_d;
			rservo_q <= wservo_d;
			rswr_q   <= wswr_d;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.motor_duty    = rduty_q;
	assign res.duty_written  = rdwr_q;
	assign res.fwd_pin       = rpins_q[0];
	assign res.rev_pin       = rpins_q[1];
	assign res.hard_brake    = rpins_q[2];
	assign res.servo_duty    = rservo_q;
	assign res.servo_written = rswr_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`MDC_ASSERT_NXT(a_start_at_dispatch, cmd_take,
		busy_q && (pc_q == mdc_pkg::PC_DISPATCH), "program did not start at dispatch")
	`MDC_ASSERT_IMP(a_pc_in_program, busy_q,
		pc_q < PC_W'(mdc_pkg::PROG_LEN), "step counter ran past the program")
	`MDC_ASSERT_IMP(a_pins_exclusive, 1'b1,
		$onehot0(pins_q), "more than one direction or brake line active")
	`MDC_ASSERT_IMP(a_duty_limit, out_valid_q,
		rduty_q <= DUTY_MAX_D, "motor duty above limit")
	`MDC_ASSERT_IMP(a_duty_zero_unwritten, out_valid_q && !rdwr_q,
		rduty_q == '0, "motor duty nonzero while not written")

endmodule
